// ----- sv/ttm_pkg.sv -----
// shared types, codes and helpers of the timer table manager
package ttm_pkg;

  localparam int unsigned SlotsDef = 16;
  localparam logic [31:0] WindowRst = 32'd3600000;

  localparam logic [2:0] REQ_ADD     = 3'd0;
  localparam logic [2:0] REQ_CANCEL  = 3'd1;
  localparam logic [2:0] REQ_REFRESH = 3'd2;
  localparam logic [2:0] REQ_RESET   = 3'd3;
  localparam logic [2:0] REQ_QUERY   = 3'd4;
  localparam logic [2:0] REQ_EXPIRE  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INACT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SCAN,
    CMD_ADD_WR,
    CMD_CANCEL,
    CMD_REFRESH,
    CMD_RST_START,
    CMD_RST_WR,
    CMD_FRONT_RES,
    CMD_QUERY_RES,
    CMD_ROLL,
    CMD_PICK_INIT,
    CMD_EMIT,
    CMD_PLAIN
  } cmd_e;

  typedef enum logic [2:0] {
    SC_ADD,
    SC_FRONT,
    SC_MIN,
    SC_DUE,
    SC_PICK
  } scan_e;

  typedef struct packed {
    cmd_e       cmd;
    scan_e      mode;
    logic [1:0] status;
  } ttm_cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       scan_last;
    logic       rst_noop;
    logic       rst_go;
    logic       any_now;
    logic       due_any;
    logic       due_more;
  } ttm_stat_t;

  // start + period, held at all ones on overflow
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [31:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {33'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

endpackage

// ----- sv/timer_table_manager_unit.sv -----
// Timer table manager: SLOTS timer slots with add, cancel, refresh, period
// reset, next-delay query and expiry.
// Request channel: drive the fields with start high; the beat is taken at a
// clock edge where busy is low. busy stays high until the request is done.
// Result channel: each result beat is shown for one cycle with done_o high;
// last_o marks the final beat of a request. The receiver cannot stall.
// Config channel: cfg_valid_i/cfg_ready_o write the rollover window; ready
// is always high. Write only while the block is idle.
// Add, reset with a position check and query scan the slot table, one
// entry per cycle; cancel, refresh and other requests use no scan.
// Expire scans the table once to mark the due timers, then once more for
// each expired timer to find the next one in deadline order. An expire on
// an empty table or with nothing due gives no result beat.
// Reset: all slots free, front notice clear, last seen time zero, window
// 3600000 ms.
module timer_table_manager_unit #(
  parameter int unsigned SLOTS = ttm_pkg::SlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type_i,
  input  logic [63:0] now_ms_i,
  input  logic [3:0]  timer_id_i,
  input  logic [31:0] period_ms_i,
  input  logic        recurring_i,
  input  logic        restart_now_i,
  output logic        done_o,
  output logic [3:0]  slot_id_o,
  output logic [1:0]  status_o,
  output logic        earliest_o,
  output logic [63:0] delay_ms_o,
  output logic        any_active_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);
  import ttm_pkg::*;

  ttm_cmd_t  cmd;
  ttm_stat_t stat;

  assign cfg_ready_o = 1'b1;

  ttm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  ttm_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_type_i    (req_type_i),
    .now_ms_i      (now_ms_i),
    .timer_id_i    (timer_id_i),
    .period_ms_i   (period_ms_i),
    .recurring_i   (recurring_i),
    .restart_now_i (restart_now_i),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .slot_id_o     (slot_id_o),
    .status_o      (status_o),
    .earliest_o    (earliest_o),
    .delay_ms_o    (delay_ms_o),
    .any_active_o  (any_active_o),
    .last_o        (last_o)
  );

endmodule

// ----- sv/ttm_ctrl.sv -----
// sequencer of the timer table manager
module ttm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  output ttm_pkg::ttm_cmd_t cmd_o,
  input  ttm_pkg::ttm_stat_t stat_i
);
  import ttm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_ADD_SCAN, S_ADD_WR, S_CANCEL, S_REFRESH,
    S_RST_CHK, S_RST_WR, S_FRONT_SCAN, S_FRONT_RES, S_Q_SCAN, S_Q_RES,
    S_EXP_CHK, S_DUE_SCAN, S_EXP_DEC, S_PICK_SCAN, S_EMIT, S_PLAIN
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;
  logic [1:0] plain_st;

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

  always_comb begin
    state_d       = state_q;
    done_d        = 1'b0;
    cmd_o.cmd     = CMD_NONE;
    cmd_o.mode    = SC_ADD;
    cmd_o.status  = ST_OK;
    plain_st      = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.cmd = CMD_LOAD;
          state_d   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority case (stat_i.req)
          REQ_ADD:     state_d = S_ADD_SCAN;
          REQ_CANCEL:  state_d = S_CANCEL;
          REQ_REFRESH: state_d = S_REFRESH;
          REQ_RESET:   state_d = S_RST_CHK;
          REQ_QUERY:   state_d = S_Q_SCAN;
          REQ_EXPIRE:  state_d = S_EXP_CHK;
          default:     state_d = S_PLAIN;
        endcase
      end
      S_ADD_SCAN: begin
        cmd_o.cmd  = CMD_SCAN;
        cmd_o.mode = SC_ADD;
        if (stat_i.scan_last) state_d = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd_o.cmd = CMD_ADD_WR;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end
      S_CANCEL: begin
        cmd_o.cmd = CMD_CANCEL;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end
      S_REFRESH: begin
        cmd_o.cmd = CMD_REFRESH;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end
      S_RST_CHK: begin
        if (!stat_i.rst_noop && stat_i.rst_go) begin
          cmd_o.cmd = CMD_RST_START;
          state_d   = S_RST_WR;
        end else begin
          plain_st     = stat_i.rst_noop ? ST_OK : ST_INACT;
          cmd_o.cmd    = CMD_PLAIN;
          cmd_o.status = plain_st;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_RST_WR: begin
        cmd_o.cmd = CMD_RST_WR;
        state_d   = S_FRONT_SCAN;
      end
      S_FRONT_SCAN: begin
        cmd_o.cmd  = CMD_SCAN;
        cmd_o.mode = SC_FRONT;
        if (stat_i.scan_last) state_d = S_FRONT_RES;
      end
      S_FRONT_RES: begin
        cmd_o.cmd = CMD_FRONT_RES;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end
      S_Q_SCAN: begin
        cmd_o.cmd  = CMD_SCAN;
        cmd_o.mode = SC_MIN;
        if (stat_i.scan_last) state_d = S_Q_RES;
      end
      S_Q_RES: begin
        cmd_o.cmd = CMD_QUERY_RES;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end
      S_EXP_CHK: begin
        // an empty table gives no beat and keeps the last seen time
        if (stat_i.any_now) begin
          cmd_o.cmd = CMD_ROLL;
          state_d   = S_DUE_SCAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DUE_SCAN: begin
        cmd_o.cmd  = CMD_SCAN;
        cmd_o.mode = SC_DUE;
        if (stat_i.scan_last) state_d = S_EXP_DEC;
      end
      S_EXP_DEC: begin
        if (stat_i.due_any) begin
          cmd_o.cmd = CMD_PICK_INIT;
          state_d   = S_PICK_SCAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_PICK_SCAN: begin
        cmd_o.cmd  = CMD_SCAN;
        cmd_o.mode = SC_PICK;
        if (stat_i.scan_last) state_d = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.cmd = CMD_EMIT;
        done_d    = 1'b1;
        state_d   = stat_i.due_more ? S_PICK_SCAN : S_IDLE;
      end
      S_PLAIN: begin
        cmd_o.cmd = CMD_PLAIN;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

endmodule

// ----- sv/ttm_datapath.sv -----
// slot storage, scan accumulators and result registers
module ttm_datapath #(
  parameter int unsigned SLOTS = ttm_pkg::SlotsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         req_type_i,
  input  logic [63:0]        now_ms_i,
  input  logic [3:0]         timer_id_i,
  input  logic [31:0]        period_ms_i,
  input  logic               recurring_i,
  input  logic               restart_now_i,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_data_i,
  input  ttm_pkg::ttm_cmd_t  cmd_i,
  output ttm_pkg::ttm_stat_t stat_o,
  output logic [3:0]         slot_id_o,
  output logic [1:0]         status_o,
  output logic               earliest_o,
  output logic [63:0]        delay_ms_o,
  output logic               any_active_o,
  output logic               last_o
);
  import ttm_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SLOTS-1:0] active_q, due_q, cancel_sel, due_rest;
  logic [63:0]      dl_q [SLOTS];
  logic [31:0]      pd_q [SLOTS];
  logic             rc_q [SLOTS];

  logic [2:0]  req_q;
  logic [63:0] now_q, tgt_q, best_q, start_q, last_seen_q;
  logic [3:0]  id_q;
  logic [31:0] per_q, window_q;
  logic        rec_q, fromnow_q, pending_q, rollover_q;
  logic [IdxW-1:0] idx_q, best_idx_q, free_idx_q, tgt_idx_q;
  logic        found_q, free_found_q, earlier_q, any_after_q;

  logic [3:0]  slot_q;
  logic [1:0]  status_q;
  logic        front_q, any_q, last_q;
  logic [63:0] delay_q;

  logic [IdxW-1:0] id_idx, rd_idx;
  logic        id_ok, e_act, e_rc, lt_tgt, eq_tgt, lt_best, le_now, e_due, front;
  logic [63:0] e_dl;
  logic [31:0] e_pd;

  assign id_idx = IdxW'(id_q);
  assign id_ok  = (32'(id_q) < SLOTS);

  always_comb begin
    priority case (cmd_i.cmd)
      CMD_SCAN: rd_idx = idx_q;
      CMD_EMIT: rd_idx = best_idx_q;
      default:  rd_idx = id_idx;
    endcase
  end

  assign e_act   = active_q[rd_idx];
  assign e_dl    = dl_q[rd_idx];
  assign e_pd    = pd_q[rd_idx];
  assign e_rc    = rc_q[rd_idx];
  assign lt_tgt  = (e_dl < tgt_q);
  assign eq_tgt  = (e_dl == tgt_q);
  assign lt_best = (e_dl < best_q);
  assign le_now  = (e_dl <= now_q);
  assign e_due   = e_act && (rollover_q || le_now);
  assign front   = !earlier_q && !pending_q;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      cancel_sel[i] = id_ok && (IdxW'(i) == id_idx);
      due_rest[i]   = due_q[i] && (IdxW'(i) != best_idx_q);
    end
  end

  assign stat_o.req       = req_q;
  assign stat_o.scan_last = (idx_q == IdxW'(SLOTS - 1));
  assign stat_o.rst_noop  = (per_q == (id_ok ? e_pd : 32'd0)) && !fromnow_q;
  assign stat_o.rst_go    = id_ok && e_act;
  assign stat_o.any_now   = |active_q;
  assign stat_o.due_any   = |due_q;
  assign stat_o.due_more  = |due_rest;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      due_q       <= '0;
      pending_q   <= 1'b0;
      last_seen_q <= '0;
      window_q    <= WindowRst;
    end else begin
      if (cfg_we_i) window_q <= cfg_data_i;
      unique case (cmd_i.cmd)
        CMD_SCAN: begin
          if (cmd_i.mode == SC_DUE) due_q[idx_q] <= e_due;
        end
        CMD_ADD_WR: begin
          if (free_found_q) begin
            active_q[free_idx_q] <= 1'b1;
            if (front) pending_q <= 1'b1;
          end
        end
        CMD_CANCEL: begin
          active_q <= active_q & ~(cancel_sel & active_q);
        end
        CMD_FRONT_RES: begin
          if (front) pending_q <= 1'b1;
        end
        CMD_QUERY_RES: pending_q <= 1'b0;
        CMD_ROLL: last_seen_q <= now_q;
        CMD_EMIT: begin
          due_q[best_idx_q] <= 1'b0;
          if (!e_rc) active_q[best_idx_q] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload: request copy, slot entries, scan accumulators, results
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.cmd)
      CMD_LOAD: begin
        req_q        <= req_type_i;
        now_q        <= now_ms_i;
        id_q         <= timer_id_i;
        per_q        <= period_ms_i;
        rec_q        <= recurring_i;
        fromnow_q    <= restart_now_i;
        tgt_q        <= sat_add(now_ms_i, period_ms_i);
        idx_q        <= '0;
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
        earlier_q    <= 1'b0;
      end
      CMD_SCAN: begin
        idx_q <= idx_q + 1'b1;
        unique case (cmd_i.mode)
          SC_ADD: begin
            if (!e_act) begin
              if (!free_found_q) begin
                free_found_q <= 1'b1;
                free_idx_q   <= idx_q;
              end
            end else if (free_found_q ? lt_tgt : (lt_tgt || eq_tgt)) begin
              earlier_q <= 1'b1;
            end
          end
          SC_FRONT: begin
            if (e_act && idx_q != tgt_idx_q && (lt_tgt || (eq_tgt && idx_q < tgt_idx_q)))
              earlier_q <= 1'b1;
          end
          SC_MIN: begin
            if (e_act && (!found_q || lt_best)) begin
              best_q  <= e_dl;
              found_q <= 1'b1;
            end
          end
          SC_DUE: begin
            if (e_act && !(e_due && !e_rc)) any_after_q <= 1'b1;
          end
          SC_PICK: begin
            if (due_q[idx_q] && (!found_q || lt_best)) begin
              best_q     <= e_dl;
              best_idx_q <= idx_q;
              found_q    <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      CMD_ADD_WR: begin
        delay_q <= '0;
        any_q   <= 1'b1;
        last_q  <= 1'b1;
        if (free_found_q) begin
          dl_q[free_idx_q] <= tgt_q;
          pd_q[free_idx_q] <= per_q;
          rc_q[free_idx_q] <= rec_q;
          slot_q   <= 4'(free_idx_q);
          status_q <= ST_OK;
          front_q  <= front;
        end else begin
          slot_q   <= '0;
          status_q <= ST_FULL;
          front_q  <= 1'b0;
        end
      end
      CMD_CANCEL: begin
        slot_q   <= id_q;
        status_q <= stat_o.rst_go ? ST_OK : ST_INACT;
        front_q  <= 1'b0;
        delay_q  <= '0;
        any_q    <= |(active_q & ~cancel_sel);
        last_q   <= 1'b1;
      end
      CMD_REFRESH: begin
        if (stat_o.rst_go) dl_q[rd_idx] <= sat_add(now_q, e_pd);
        slot_q   <= id_q;
        status_q <= stat_o.rst_go ? ST_OK : ST_INACT;
        front_q  <= 1'b0;
        delay_q  <= '0;
        any_q    <= |active_q;
        last_q   <= 1'b1;
      end
      CMD_RST_START: begin
        // measured from now on a restart, else from the previous start, clamped at zero
        if (fromnow_q)          start_q <= now_q;
        else if (e_dl >= 64'(e_pd)) start_q <= e_dl - 64'(e_pd);
        else                    start_q <= '0;
        tgt_idx_q <= id_idx;
      end
      CMD_RST_WR: begin
        tgt_q        <= sat_add(start_q, per_q);
        dl_q[rd_idx] <= sat_add(start_q, per_q);
        pd_q[rd_idx] <= per_q;
        idx_q        <= '0;
        earlier_q    <= 1'b0;
      end
      CMD_FRONT_RES: begin
        slot_q   <= id_q;
        status_q <= ST_OK;
        front_q  <= front;
        delay_q  <= '0;
        any_q    <= |active_q;
        last_q   <= 1'b1;
      end
      CMD_QUERY_RES: begin
        slot_q   <= '0;
        status_q <= ST_OK;
        front_q  <= 1'b0;
        if (!found_q)           delay_q <= '1;
        else if (now_q >= best_q) delay_q <= '0;
        else                    delay_q <= best_q - now_q;
        any_q    <= |active_q;
        last_q   <= 1'b1;
      end
      CMD_ROLL: begin
        rollover_q  <= (now_q < last_seen_q) &&
                       ((last_seen_q - now_q) > 64'(window_q));
        any_after_q <= 1'b0;
        idx_q       <= '0;
      end
      CMD_PICK_INIT: begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end
      CMD_EMIT: begin
        if (e_rc) dl_q[rd_idx] <= sat_add(now_q, e_pd);
        slot_q   <= 4'(best_idx_q);
        status_q <= ST_OK;
        front_q  <= 1'b0;
        delay_q  <= '0;
        any_q    <= any_after_q;
        last_q   <= !(|due_rest);
        idx_q    <= '0;
        found_q  <= 1'b0;
      end
      CMD_PLAIN: begin
        slot_q   <= (req_q == REQ_RESET) ? id_q : 4'd0;
        status_q <= cmd_i.status;
        front_q  <= 1'b0;
        delay_q  <= '0;
        any_q    <= |active_q;
        last_q   <= 1'b1;
      end
      default: ;
    endcase
  end

  assign slot_id_o    = slot_q;
  assign status_o     = status_q;
  assign earliest_o   = front_q;
  assign delay_ms_o   = delay_q;
  assign any_active_o = any_q;
  assign last_o       = last_q;

endmodule

// ----- sv/ttm_checker.sv -----
// port-level checks of the timer table manager and their bind
module ttm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [1:0] status_o,
  input logic       earliest_o,
  input logic       any_active_o,
  input logic       last_o
);
  import ttm_pkg::*;

  // an accepted request makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted request did not raise busy");

  // more beats pending means the request is still in progress
  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !last_o |-> busy) else $error("non-final beat while idle");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_FULL |-> any_active_o && last_o && !earliest_o)
    else $error("bad table-full beat");

  a_inact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_INACT |-> last_o && !earliest_o)
    else $error("bad inactive-slot beat");

  a_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && earliest_o |-> any_active_o && status_o == ST_OK)
    else $error("front mark without an active timer");

endmodule

bind timer_table_manager_unit ttm_checker u_ttm_checker (.*);

// ----- sim/ttm_checker.sv -----
// scoreboard of the timer table manager: predicts every result beat and compares
`timescale 1ns / 1ps

module ttm_scoreboard #(
  parameter int unsigned NSLOT = ttm_pkg::SlotsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [2:0]        req_type_i,
  input  logic [63:0]       now_ms_i,
  input  logic [3:0]        timer_id_i,
  input  logic [31:0]       period_ms_i,
  input  logic              recurring_i,
  input  logic              restart_now_i,
  input  logic              done_i,
  input  logic [3:0]        slot_id_i,
  input  logic [1:0]        status_i,
  input  logic              earliest_i,
  input  logic [63:0]       delay_ms_i,
  input  logic              any_active_i,
  input  logic              last_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [31:0]       cfg_data_i,
  output int unsigned       errors_o,
  output int unsigned       pending_o,
  output logic [NSLOT-1:0]  active_o,
  output logic [NSLOT-1:0]  period_known_o
);
  import ttm_pkg::*;

  typedef struct packed {
    logic [3:0]  slot;
    logic [1:0]  status;
    logic        front;
    logic [63:0] delay;
    logic        any;
    logic        last;
  } beat_t;

  beat_t       result_q[$];
  logic        tm_active[NSLOT];
  logic [63:0] tm_deadline[NSLOT];
  logic [31:0] tm_period[NSLOT];
  logic        tm_recur[NSLOT];
  logic        front_pending;
  logic [63:0] last_seen;
  logic [31:0] window;

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [31:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {33'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic any_timer();
    for (int i = 0; i < NSLOT; i++) if (tm_active[i]) return 1'b1;
    return 1'b0;
  endfunction

  // slot s is first in deadline order and the front notice was clear, which it then sets
  function automatic logic claim_front(int s);
    for (int j = 0; j < NSLOT; j++) begin
      if (j == s || !tm_active[j]) continue;
      if (tm_deadline[j] < tm_deadline[s]) return 1'b0;
      if (tm_deadline[j] == tm_deadline[s] && j < s) return 1'b0;
    end
    if (front_pending) return 1'b0;
    front_pending = 1'b1;
    return 1'b1;
  endfunction

  function automatic beat_t mk(logic [3:0] slot, logic [1:0] st, logic fr, logic [63:0] d);
    beat_t b;
    b.slot = slot; b.status = st; b.front = fr; b.delay = d; b.any = 0; b.last = 0;
    return b;
  endfunction

  task automatic predict_request(logic [2:0] req, logic [63:0] now, logic [3:0] id,
                                 logic [31:0] per, logic rec, logic fn);
    beat_t       outs[$];
    int          s;
    logic [63:0] best, st;
    logic        found, roll;
    logic        due[NSLOT];
    logic        act;
    case (req)
      REQ_ADD: begin
        s = -1;
        for (int i = 0; i < NSLOT; i++) if (!tm_active[i]) begin s = i; break; end
        if (s < 0) outs.insert(outs.size(), mk(0, ST_FULL, 0, 0));
        else begin
          tm_active[s] = 1; tm_period[s] = per; tm_recur[s] = rec;
          tm_deadline[s] = add_sat(now, per);
          period_known_o[s] = 1'b1;
          outs.insert(outs.size(), mk(s[3:0], ST_OK, claim_front(s), 0));
        end
      end
      REQ_CANCEL: begin
        if (tm_active[id]) begin
          tm_active[id] = 0;
          outs.insert(outs.size(), mk(id, ST_OK, 0, 0));
        end else outs.insert(outs.size(), mk(id, ST_INACT, 0, 0));
      end
      REQ_REFRESH: begin
        if (tm_active[id]) begin
          tm_deadline[id] = add_sat(now, tm_period[id]);
          outs.insert(outs.size(), mk(id, ST_OK, 0, 0));
        end else outs.insert(outs.size(), mk(id, ST_INACT, 0, 0));
      end
      REQ_RESET: begin
        if (per == tm_period[id] && !fn) outs.insert(outs.size(), mk(id, ST_OK, 0, 0));
        else if (tm_active[id]) begin
          if (fn) st = now;
          else st = (tm_deadline[id] >= {32'b0, tm_period[id]}) ?
                    tm_deadline[id] - tm_period[id] : 64'd0;
          tm_period[id] = per;
          tm_deadline[id] = add_sat(st, per);
          outs.insert(outs.size(), mk(id, ST_OK, claim_front(id), 0));
        end else outs.insert(outs.size(), mk(id, ST_INACT, 0, 0));
      end
      REQ_QUERY: begin
        front_pending = 0;
        found = 0; best = '0;
        for (int i = 0; i < NSLOT; i++)
          if (tm_active[i] && (!found || tm_deadline[i] < best)) begin
            best = tm_deadline[i]; found = 1;
          end
        outs.insert(outs.size(),
                    mk(0, ST_OK, 0, !found ? '1 : (now >= best ? 64'd0 : best - now)));
      end
      REQ_EXPIRE: begin
        if (any_timer()) begin
          roll = now < last_seen && (last_seen - now) > {32'b0, window};
          last_seen = now;
          for (int i = 0; i < NSLOT; i++)
            due[i] = tm_active[i] && (roll || tm_deadline[i] <= now);
          forever begin
            s = -1;
            for (int i = 0; i < NSLOT; i++)
              if (due[i] && (s < 0 || tm_deadline[i] < tm_deadline[s])) s = i;
            if (s < 0) break;
            due[s] = 0;
            if (tm_recur[s]) tm_deadline[s] = add_sat(now, tm_period[s]);
            else tm_active[s] = 0;
            outs.insert(outs.size(), mk(s[3:0], ST_OK, 0, 0));
          end
        end
      end
      default: outs.insert(outs.size(), mk(0, ST_OK, 0, 0));
    endcase
    act = any_timer();
    foreach (outs[k]) begin
      outs[k].any = act;
      outs[k].last = (k == outs.size() - 1);
      result_q.insert(result_q.size(), outs[k]);
    end
    for (int i = 0; i < NSLOT; i++) active_o[i] = tm_active[i];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t want, got;
    if (!rst_ni) begin
      for (int i = 0; i < NSLOT; i++) begin
        tm_active[i] = 0; tm_deadline[i] = '0; tm_period[i] = '0; tm_recur[i] = 0;
      end
      front_pending = 0;
      last_seen = '0;
      window = WindowRst;
      result_q.delete();
      errors_o = 0;
      active_o = '0;
      period_known_o = '0;
    end else begin
      if (done_i) begin
        got.slot = slot_id_i; got.status = status_i; got.front = earliest_i;
        got.delay = delay_ms_i; got.any = any_active_i; got.last = last_i;
        if (result_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("%0t: result beat with nothing expected: %p", $time, got);
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            errors_o++;
            if (errors_o <= 10) $display("%0t: mismatch expected %p actual %p", $time, want, got);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) window = cfg_data_i;
      if (start_i && !busy_i)
        predict_request(req_type_i, now_ms_i, timer_id_i, period_ms_i, recurring_i,
                        restart_now_i);
    end
    pending_o = result_q.size();
  end

endmodule

// ----- sim/testbench.sv -----
// top of the timer table manager testbench: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module testbench;
  import ttm_pkg::*;

  localparam int unsigned NSLOT = SlotsDef;
  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;
  localparam int unsigned DogLimit = 5000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  req_type = '0;
  logic [63:0] now_ms = '0;
  logic [3:0]  timer_id = '0;
  logic [31:0] period_ms = '0;
  logic        recurring = 0;
  logic        restart_now = 0;
  logic        done;
  logic [3:0]  slot_id;
  logic [1:0]  status;
  logic        earliest;
  logic [63:0] delay_ms;
  logic        any_active;
  logic        last;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  int unsigned       errors, pending, idle_pct, dog;
  logic [NSLOT-1:0]  active_map, period_known;
  logic [63:0]       clock_ms;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  timer_table_manager_unit #(.SLOTS(NSLOT)) u_dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy),
    .req_type_i(req_type), .now_ms_i(now_ms), .timer_id_i(timer_id),
    .period_ms_i(period_ms), .recurring_i(recurring), .restart_now_i(restart_now),
    .done_o(done), .slot_id_o(slot_id), .status_o(status), .earliest_o(earliest),
    .delay_ms_o(delay_ms), .any_active_o(any_active), .last_o(last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  ttm_scoreboard #(.NSLOT(NSLOT)) u_check (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .req_type_i(req_type), .now_ms_i(now_ms), .timer_id_i(timer_id),
    .period_ms_i(period_ms), .recurring_i(recurring), .restart_now_i(restart_now),
    .done_i(done), .slot_id_i(slot_id), .status_i(status), .earliest_i(earliest),
    .delay_ms_i(delay_ms), .any_active_i(any_active), .last_i(last),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending), .active_o(active_map),
    .period_known_o(period_known)
  );

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n) dog <= 0;
    else if (dog >= DogLimit) begin
      $display("testbench NOT OK");
      $finish;
    end else dog <= dog + 1;
  end

  // leaves start high after the beat, so a following request goes back to back
  task automatic issue(logic [2:0] rq, logic [63:0] t, logic [3:0] id,
                       logic [31:0] per, logic rec, logic fn);
    req_type <= rq; now_ms <= t; timer_id <= id;
    period_ms <= per; recurring <= rec; restart_now <= fn;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic gap();
    int n;
    if ($urandom_range(99) < idle_pct) begin
      n = $urandom_range(1, 12);
      start <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    // idle margin after busy has dropped; an expire with nothing due has finished by now
    repeat (2 * NSLOT + 16) @(posedge clk);
  endtask

  task automatic write_window(logic [31:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] pick_period();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(0, 100);
    if (r < 70) return $urandom_range(0, 5000);
    if (r < 80) return 32'd0;
    if (r < 85) return '1;
    return $urandom;
  endfunction

  function automatic logic [3:0] pick_slot();
    logic [3:0] id;
    if (active_map != 0 && $urandom_range(99) < 75) begin
      do id = 4'($urandom_range(0, NSLOT - 1)); while (!active_map[id]);
      return id;
    end
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic random_request();
    int          r;
    logic [2:0]  rq;
    logic [3:0]  id;
    logic        fn;
    r = $urandom_range(99);
    if (r < 70) clock_ms += $urandom_range(0, 60);
    else if (r < 78) clock_ms -= $urandom_range(0, 200);
    else if (r < 84) clock_ms -= $urandom_range(0, 8000000);
    else if (r < 88) clock_ms = {$urandom, $urandom};
    else if (r < 91) clock_ms = '1 - $urandom_range(0, 3000);
    r = $urandom_range(99);
    if (r < 26) rq = REQ_ADD;
    else if (r < 38) rq = REQ_CANCEL;
    else if (r < 48) rq = REQ_REFRESH;
    else if (r < 63) rq = REQ_RESET;
    else if (r < 75) rq = REQ_QUERY;
    else if (r < 96) rq = REQ_EXPIRE;
    else rq = r[0] ? REQ_SPARE7 : REQ_SPARE6;
    id = pick_slot();
    fn = 1'($urandom_range(0, 1));
    // a reset measured from the old start must not read a period never written
    if (rq == REQ_RESET && !fn && !period_known[id]) fn = 1;
    issue(rq, clock_ms, id, pick_period(), 1'($urandom_range(0, 1)), fn);
  endtask

  initial begin
    logic [31:0] windows[6];
    int          phase_idle[6];
    windows = '{32'd0, 32'hFFFF_FFFF, WindowRst, 32'd50, 32'd0, 32'd1000};
    windows[4] = $urandom;
    phase_idle = '{0, 69, 31, 0, 69, 31};
    idle_pct = 0;
    clock_ms = 64'd1000;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: fill the table, overflow it, then each operation at least once
    issue(REQ_ADD, 64'd100, 0, 32'd100, 1'b0, 1'b0);
    issue(REQ_ADD, '1, 0, '1, 1'b1, 1'b0);
    issue(REQ_ADD, '1 - 64'd5, 0, 32'd3, 1'b0, 1'b0);
    issue(REQ_ADD, 64'd0, 0, 32'd0, 1'b1, 1'b0);
    for (int i = 4; i < NSLOT; i++) issue(REQ_ADD, 64'd50, 0, 32'd20 + i, i[0], 1'b0);
    issue(REQ_ADD, 64'd60, 0, 32'd5, 1'b1, 1'b0);
    issue(REQ_QUERY, 64'd10, 0, 0, 0, 0);
    issue(REQ_RESET, 64'd20, 4'd0, 32'd100, 1'b0, 1'b0);
    issue(REQ_RESET, 64'd20, 4'd5, 32'd7, 1'b0, 1'b1);
    issue(REQ_RESET, 64'd30, 4'd4, 32'd2, 1'b0, 1'b0);
    issue(REQ_REFRESH, 64'd40, 4'd6, 0, 0, 0);
    issue(REQ_CANCEL, 64'd40, 4'd15, 0, 0, 0);
    issue(REQ_CANCEL, 64'd40, 4'd15, 0, 0, 0);
    issue(REQ_REFRESH, 64'd40, 4'd15, 0, 0, 0);
    issue(REQ_RESET, 64'd40, 4'd15, 32'd9, 0, 1'b1);
    issue(REQ_EXPIRE, 64'd75, 0, 0, 0, 0);
    issue(REQ_EXPIRE, 64'd76, 0, 0, 0, 0);
    issue(REQ_EXPIRE, 64'd0, 0, 0, 0, 0);
    issue(REQ_SPARE6, 64'd0, 0, 0, 0, 0);
    issue(REQ_SPARE7, '1, '1, '1, 1'b1, 1'b1);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_window(windows[p]);
      idle_pct = phase_idle[p];
      for (int n = 0; n < 68; n++) begin
        random_request();
        if (n == 34 && p == 2) drain();
        else gap();
      end
      drain();
    end

    if (errors == 0 && pending == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule
